@@ src/tbfd_pkg.sv @@
// Shared types and constants for the tagged bit-field deframer.
`default_nettype none
package tbfd_pkg;

    localparam int CALLSIGN_BYTES = 10;
    localparam int ID_BYTES       = 5;

    // Field codes; the active field register uses FIELD_IDLE when no field is selected.
    localparam logic [3:0] FIELD_DEST     = 4'd0;
    localparam logic [3:0] FIELD_SRC      = 4'd1;
    localparam logic [3:0] FIELD_DOWN     = 4'd2;
    localparam logic [3:0] FIELD_UP       = 4'd3;
    localparam logic [3:0] FIELD_DOWN_ID  = 4'd4;
    localparam logic [3:0] FIELD_UP_ID    = 4'd5;
    localparam logic [3:0] FIELD_VOIP_ID  = 4'd6;
    localparam logic [3:0] FIELD_RADIO_ID = 4'd7;
    localparam logic [3:0] FIELD_IDLE     = 4'd8;

    localparam logic [3:0] TAG_CSD1     = 4'd0;
    localparam logic [3:0] TAG_DEST     = 4'd1;
    localparam logic [3:0] TAG_CSD2     = 4'd2;
    localparam logic [3:0] TAG_DOWN     = 4'd3;
    localparam logic [3:0] TAG_SRC      = 4'd4;
    localparam logic [3:0] TAG_UP       = 4'd5;
    localparam logic [3:0] TAG_REM12    = 4'd6;
    localparam logic [3:0] TAG_REM34    = 4'd7;
    localparam logic [3:0] TAG_RESET    = 4'd15;

    localparam int QUEUE_DEPTH = 2;

    // One classified input item as it travels from the front to the back.
    typedef struct packed {
        logic       data_bit;
        logic       tag_valid;
        logic [3:0] tag_code;
        logic       tag_selects;  // The tag maps to a field.
        logic [3:0] tag_field;    // Field selected by the tag when tag_selects is set.
    } cmd_t;

endpackage
`default_nettype wire

@@ src/tagged_bit_field_deframer_top.sv @@
// Top level of the tagged bit-field deframer.
// Takes one received bit per transaction, optionally tagged with a field code, packs the
// bits first-received-as-MSB into bytes of the selected field and emits one transaction
// per completed byte with its field, value, index and a last flag. A new transaction is
// accepted every clock while the two-entry command queue has room; the back end drains
// that queue at one item per clock as long as the single output register is free or being
// taken, so the sustained rate is one item per cycle. Each input item is held in a queue
// entry until the back end takes it, and each completed byte is held in the output register.
`default_nettype none
module tagged_bit_field_deframer_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [0] data_bit, [7:1] zero
    input  wire logic [4:0]  s_tuser,   // [0] tag_valid, [4:1] tag_code
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] byte_value, [11:8] byte_index, [15:12] zero
    output logic [2:0]       m_tuser,   // [2:0] field_id
    output logic             m_tlast    // field_last
);

    tbfd_pkg::cmd_t front_cmd, back_cmd;
    logic           front_valid, front_ready;
    logic           back_valid, back_ready;
    logic [7:0]     byte_value;
    logic [3:0]     byte_index;

    tbfd_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .data_bit  (s_tdata[0]),
        .tag_valid (s_tuser[0]),
        .tag_code  (s_tuser[4:1]),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    tbfd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_cmd   (front_cmd),
        .rd_valid (back_valid),
        .rd_ready (back_ready),
        .rd_cmd   (back_cmd)
    );

    tbfd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd_valid  (back_valid),
        .cmd_ready  (back_ready),
        .cmd        (back_cmd),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .field_id   (m_tuser),
        .byte_value (byte_value),
        .byte_index (byte_index),
        .field_last (m_tlast)
    );

    assign m_tdata = {4'd0, byte_index, byte_value};

endmodule
`default_nettype wire

@@ src/tbfd_front.sv @@
// Front end: accepts input transactions and classifies the tag into a field command.
`default_nettype none
module tbfd_front (
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic        data_bit,
    input  wire logic        tag_valid,
    input  wire logic [3:0]  tag_code,
    output logic             cmd_valid,
    input  wire logic        cmd_ready,
    output tbfd_pkg::cmd_t   cmd
);

    always_comb begin
        cmd.data_bit    = data_bit;
        cmd.tag_valid   = tag_valid;
        cmd.tag_code    = tag_code;
        cmd.tag_selects = 1'b1;
        unique case (tag_code)
            tbfd_pkg::TAG_CSD1, tbfd_pkg::TAG_DEST: cmd.tag_field = tbfd_pkg::FIELD_DEST;
            tbfd_pkg::TAG_CSD2, tbfd_pkg::TAG_DOWN: cmd.tag_field = tbfd_pkg::FIELD_DOWN;
            tbfd_pkg::TAG_SRC:   cmd.tag_field = tbfd_pkg::FIELD_SRC;
            tbfd_pkg::TAG_UP:    cmd.tag_field = tbfd_pkg::FIELD_UP;
            tbfd_pkg::TAG_REM12: cmd.tag_field = tbfd_pkg::FIELD_DOWN_ID;
            tbfd_pkg::TAG_REM34: cmd.tag_field = tbfd_pkg::FIELD_VOIP_ID;
            default: begin
                cmd.tag_field   = tbfd_pkg::FIELD_IDLE;
                cmd.tag_selects = 1'b0;
            end
        endcase
    end

    assign cmd_valid = s_tvalid;
    assign s_tready  = cmd_ready;

endmodule
`default_nettype wire

@@ src/tbfd_queue.sv @@
// Short command queue between the front end and the back end.
`default_nettype none
module tbfd_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            wr_valid,
    output logic                 wr_ready,
    input  wire tbfd_pkg::cmd_t  wr_cmd,
    output logic                 rd_valid,
    input  wire logic            rd_ready,
    output tbfd_pkg::cmd_t       rd_cmd
);

    localparam int PtrW = $clog2(tbfd_pkg::QUEUE_DEPTH);
    localparam int CntW = $clog2(tbfd_pkg::QUEUE_DEPTH + 1);

    tbfd_pkg::cmd_t entry_reg [tbfd_pkg::QUEUE_DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            push, pop;

    assign wr_ready = (count_reg != CntW'(tbfd_pkg::QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_cmd   = entry_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(tbfd_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(tbfd_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule
`default_nettype wire

@@ src/tbfd_back.sv @@
// Back end: field selection, bit packing, byte counting and the output register.
`default_nettype none
module tbfd_back (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            cmd_valid,
    output logic                 cmd_ready,
    input  wire tbfd_pkg::cmd_t  cmd,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output logic [2:0]           field_id,
    output logic [7:0]           byte_value,
    output logic [3:0]           byte_index,
    output logic                 field_last
);

    logic [3:0] active_field_reg, active_field_next;
    logic [3:0] last_tag_reg, last_tag_next;
    logic [2:0] bit_pos_reg, bit_pos_next;
    logic [3:0] byte_pos_reg, byte_pos_next;
    logic [7:0] partial_reg, partial_next;

    logic       out_valid_reg, out_valid_next;
    logic [2:0] out_field_reg, out_field_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic [3:0] out_index_reg, out_index_next;
    logic       out_last_reg, out_last_next;

    logic       pop;
    logic       emit;
    logic [3:0] sel_field;
    logic [3:0] size;
    logic       done;
    logic [7:0] base_byte;

    function automatic logic [3:0] chain_field(input logic [3:0] f, input logic [3:0] tag);
        logic [3:0] r;
        r = tbfd_pkg::FIELD_IDLE;
        if (tag == tbfd_pkg::TAG_CSD1 && f == tbfd_pkg::FIELD_DEST) begin
            r = tbfd_pkg::FIELD_SRC;
        end else if (tag == tbfd_pkg::TAG_CSD2 && f == tbfd_pkg::FIELD_DOWN) begin
            r = tbfd_pkg::FIELD_UP;
        end else if (tag == tbfd_pkg::TAG_REM12 && f == tbfd_pkg::FIELD_DOWN_ID) begin
            r = tbfd_pkg::FIELD_UP_ID;
        end else if (tag == tbfd_pkg::TAG_REM34 && f == tbfd_pkg::FIELD_VOIP_ID) begin
            r = tbfd_pkg::FIELD_RADIO_ID;
        end
        return r;
    endfunction

    // An item is taken whenever the output slot is free or being drained this cycle.
    assign cmd_ready = !out_valid_reg || m_tready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb begin
        active_field_next = active_field_reg;
        last_tag_next     = last_tag_reg;
        bit_pos_next      = bit_pos_reg;
        byte_pos_next     = byte_pos_reg;
        partial_next      = partial_reg;
        emit              = 1'b0;
        done              = 1'b0;
        sel_field         = active_field_reg;
        size              = 4'(tbfd_pkg::ID_BYTES);
        base_byte         = partial_reg;

        if (pop) begin
            if (cmd.tag_valid) begin
                last_tag_next = cmd.tag_code;
                byte_pos_next = '0;
                if (cmd.tag_selects) begin
                    sel_field = cmd.tag_field;
                end
            end
            active_field_next = sel_field;

            if (sel_field < tbfd_pkg::FIELD_IDLE) begin
                base_byte    = (bit_pos_reg == 3'd7) ? 8'd0 : partial_reg;
                partial_next = base_byte | (8'(cmd.data_bit) << bit_pos_reg);
                if (bit_pos_reg != 3'd0) begin
                    bit_pos_next = bit_pos_reg - 3'd1;
                end else begin
                    emit         = 1'b1;
                    bit_pos_next = 3'd7;
                    size = (sel_field < tbfd_pkg::FIELD_DOWN_ID) ? 4'(tbfd_pkg::CALLSIGN_BYTES)
                                                                 : 4'(tbfd_pkg::ID_BYTES);
                    done = ({1'b0, byte_pos_next} + 5'd1) >= {1'b0, size};
                    if (done) begin
                        active_field_next = chain_field(sel_field, last_tag_next);
                    end
                end
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg && !m_tready;
        out_field_next = out_field_reg;
        out_byte_next  = out_byte_reg;
        out_index_next = out_index_reg;
        out_last_next  = out_last_reg;
        if (emit) begin
            out_valid_next = 1'b1;
            out_field_next = sel_field[2:0];
            out_byte_next  = partial_next;
            out_index_next = byte_pos_next;
            out_last_next  = done;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_field_reg <= tbfd_pkg::FIELD_IDLE;
            last_tag_reg     <= tbfd_pkg::TAG_RESET;
            bit_pos_reg      <= 3'd7;
            byte_pos_reg     <= '0;
            partial_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            active_field_reg <= active_field_next;
            last_tag_reg     <= last_tag_next;
            bit_pos_reg      <= bit_pos_next;
            // The byte position restarts after the last byte of a field.
            byte_pos_reg     <= (emit && done) ? 4'd0 : (emit ? byte_pos_next + 4'd1
                                                              : byte_pos_next);
            partial_reg      <= partial_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_field_reg <= out_field_next;
        out_byte_reg  <= out_byte_next;
        out_index_reg <= out_index_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign field_id   = out_field_reg;
    assign byte_value = out_byte_reg;
    assign byte_index = out_index_reg;
    assign field_last = out_last_reg;

endmodule
`default_nettype wire

@@ sim/testbench.sv @@
// Self-checking testbench for the tagged bit-field deframer top level.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1650;
    localparam int CALM_TAIL    = 300;

    typedef struct packed {
        logic [2:0] field_id;
        logic [7:0] byte_value;
        logic [3:0] byte_index;
        logic       field_last;
    } field_byte_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic [4:0]  s_tuser  = 5'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    // Mirror of the deframer state, advanced once per accepted transaction.
    logic [3:0]  sel_field   = tbfd_pkg::FIELD_IDLE;
    logic [3:0]  latest_tag  = tbfd_pkg::TAG_RESET;
    logic [2:0]  fill_bit    = 3'd7;
    logic [3:0]  fill_byte   = 4'd0;
    logic [7:0]  gather_byte = 8'h00;

    field_byte_t pending_bytes[$];
    int          error_count = 0;
    int          bits_sent   = 0;
    bit          idle_on     = 1'b0;
    int          rx_stall_left = 0;

    tagged_bit_field_deframer_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic logic [3:0] partner_field(input logic [3:0] fld, input logic [3:0] tag);
        if (tag == tbfd_pkg::TAG_CSD1 && fld == tbfd_pkg::FIELD_DEST)
            return tbfd_pkg::FIELD_SRC;
        if (tag == tbfd_pkg::TAG_CSD2 && fld == tbfd_pkg::FIELD_DOWN)
            return tbfd_pkg::FIELD_UP;
        if (tag == tbfd_pkg::TAG_REM12 && fld == tbfd_pkg::FIELD_DOWN_ID)
            return tbfd_pkg::FIELD_UP_ID;
        if (tag == tbfd_pkg::TAG_REM34 && fld == tbfd_pkg::FIELD_VOIP_ID)
            return tbfd_pkg::FIELD_RADIO_ID;
        return tbfd_pkg::FIELD_IDLE;
    endfunction

    // Bits a tag needs to fill its field and any chained partner field.
    function automatic int frame_bits(input logic [3:0] tag);
        case (tag)
            tbfd_pkg::TAG_CSD1, tbfd_pkg::TAG_CSD2:
                return 16 * tbfd_pkg::CALLSIGN_BYTES;
            tbfd_pkg::TAG_DEST, tbfd_pkg::TAG_DOWN, tbfd_pkg::TAG_SRC, tbfd_pkg::TAG_UP:
                return 8 * tbfd_pkg::CALLSIGN_BYTES;
            tbfd_pkg::TAG_REM12, tbfd_pkg::TAG_REM34:
                return 16 * tbfd_pkg::ID_BYTES;
            default:
                return 0;
        endcase
    endfunction

    task automatic deframe_bit(input logic b, input logic tv, input logic [3:0] code);
        int size;
        field_byte_t rec;
        if (tv) begin
            latest_tag = code;
            case (code)
                tbfd_pkg::TAG_CSD1, tbfd_pkg::TAG_DEST: sel_field = tbfd_pkg::FIELD_DEST;
                tbfd_pkg::TAG_CSD2, tbfd_pkg::TAG_DOWN: sel_field = tbfd_pkg::FIELD_DOWN;
                tbfd_pkg::TAG_SRC:   sel_field = tbfd_pkg::FIELD_SRC;
                tbfd_pkg::TAG_UP:    sel_field = tbfd_pkg::FIELD_UP;
                tbfd_pkg::TAG_REM12: sel_field = tbfd_pkg::FIELD_DOWN_ID;
                tbfd_pkg::TAG_REM34: sel_field = tbfd_pkg::FIELD_VOIP_ID;
                default:             ;
            endcase
            fill_byte = 4'd0;
        end
        if (sel_field < tbfd_pkg::FIELD_IDLE) begin
            if (fill_bit == 3'd7)
                gather_byte = 8'h00;
            gather_byte = gather_byte | (8'(b) << fill_bit);
            if (fill_bit != 3'd0) begin
                fill_bit = fill_bit - 3'd1;
            end else begin
                fill_bit = 3'd7;
                size = (sel_field < tbfd_pkg::FIELD_DOWN_ID) ? tbfd_pkg::CALLSIGN_BYTES
                                                             : tbfd_pkg::ID_BYTES;
                rec.field_id   = sel_field[2:0];
                rec.byte_value = gather_byte;
                rec.byte_index = fill_byte;
                rec.field_last = (int'(fill_byte) + 1 >= size);
                pending_bytes.push_back(rec);
                if (rec.field_last) begin
                    fill_byte = 4'd0;
                    sel_field = partner_field(sel_field, latest_tag);
                end else begin
                    fill_byte = fill_byte + 4'd1;
                end
            end
        end
    endtask

    // Offers one bit and waits until the deframer takes it.
    task automatic send_bit(input logic b, input logic tv, input logic [3:0] code);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, b};
        s_tuser  <= {code, tv};
        do @(posedge aclk); while (!s_tready);
        deframe_bit(b, tv, code);
        bits_sent++;
    endtask

    task automatic send_byte(input logic [7:0] value, input logic tv, input logic [3:0] code);
        for (int i = 7; i >= 0; i--)
            send_bit(value[i], (i == 7) ? tv : 1'b0, code);
    endtask

    task automatic test_idle_drop();
        send_bit(1'b1, 1'b0, tbfd_pkg::TAG_RESET);
        send_bit(1'b0, 1'b0, tbfd_pkg::TAG_CSD1);
        send_bit(1'b1, 1'b1, tbfd_pkg::TAG_RESET);
        send_bit(1'b1, 1'b1, 4'd8);
        send_bit(1'b0, 1'b0, tbfd_pkg::TAG_RESET);
    endtask

    // A short byte under each mapped tag; each new tag restarts the byte index.
    task automatic test_every_tag();
        send_byte(8'hFF, 1'b1, tbfd_pkg::TAG_CSD1);
        send_byte(8'h00, 1'b0, tbfd_pkg::TAG_RESET);
        for (int t = 1; t <= 7; t++)
            send_byte(8'($urandom), 1'b1, 4'(t));
    endtask

    // A tag arriving partway through a byte moves the gathered bits to the new field.
    task automatic test_mid_byte_tag();
        send_bit(1'b1, 1'b1, tbfd_pkg::TAG_DEST);
        send_bit(1'b0, 1'b0, tbfd_pkg::TAG_RESET);
        send_bit(1'b1, 1'b0, tbfd_pkg::TAG_RESET);
        send_bit(1'b1, 1'b1, tbfd_pkg::TAG_SRC);
        for (int i = 0; i < 4; i++)
            send_bit(1'b0, 1'b0, tbfd_pkg::TAG_RESET);
        send_byte(8'hA5, 1'b0, tbfd_pkg::TAG_RESET);
        // An unmapped tag restarts the index but keeps the source field.
        send_byte(8'h3C, 1'b1, 4'd12);
    endtask

    // A full run that chains into its partner field and falls idle, then a full run with no partner.
    task automatic test_chained_fields();
        send_byte(8'hFF, 1'b1, tbfd_pkg::TAG_REM12);
        for (int i = 1; i < 2 * tbfd_pkg::ID_BYTES; i++)
            send_byte((i == 2 * tbfd_pkg::ID_BYTES - 1) ? 8'h00 : 8'($urandom), 1'b0,
                      tbfd_pkg::TAG_RESET);
        send_byte(8'h81, 1'b0, tbfd_pkg::TAG_RESET);
        send_byte(8'($urandom), 1'b1, tbfd_pkg::TAG_UP);
        for (int i = 1; i < tbfd_pkg::CALLSIGN_BYTES; i++)
            send_byte(8'($urandom), 1'b0, tbfd_pkg::TAG_RESET);
        send_bit(1'b1, 1'b0, tbfd_pkg::TAG_RESET);
    endtask

    task automatic test_random_frames(input int n_items);
        int start;
        int len;
        int kind;
        logic [3:0] code;
        logic tv;
        start = bits_sent;
        while (bits_sent - start < n_items) begin
            idle_on = (bits_sent - start < n_items - CALM_TAIL) && ($urandom_range(0, 3) != 0);
            kind = $urandom_range(0, 19);
            code = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(0, 7))
                                              : 4'($urandom_range(8, 15));
            if (kind < 12)
                len = frame_bits(code) + $urandom_range(0, 6);
            else if (kind < 17)
                len = $urandom_range(1, (frame_bits(code) > 0) ? frame_bits(code) : 24);
            else
                len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++) begin
                if (i == 0) begin
                    tv = (kind < 17);
                end else begin
                    tv = ($urandom_range(0, 49) == 0);
                    if (tv)
                        code = 4'($urandom_range(0, 15));
                end
                send_bit(1'($urandom), tv, code);
            end
        end
        idle_on = 1'b0;
    endtask

    always @(posedge aclk) begin
        if (rx_stall_left != 0) begin
            m_tready <= 1'b0;
            rx_stall_left <= rx_stall_left - 1;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            m_tready <= 1'b0;
            rx_stall_left <= $urandom_range(0, 2);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Each result transaction is matched against the oldest predicted byte.
    always @(posedge aclk) begin
        field_byte_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_bytes.size() == 0) begin
                $error("unexpected result: field_id %0d byte_value %0h", m_tuser, m_tdata[7:0]);
                error_count++;
            end else begin
                want = pending_bytes.pop_front();
                if (m_tuser !== want.field_id) begin
                    $error("field_id mismatch: expected %0d, actual %0d", want.field_id, m_tuser);
                    error_count++;
                end
                if (m_tdata[7:0] !== want.byte_value) begin
                    $error("byte_value mismatch: expected %0h, actual %0h",
                           want.byte_value, m_tdata[7:0]);
                    error_count++;
                end
                if (m_tdata[11:8] !== want.byte_index) begin
                    $error("byte_index mismatch: expected %0d, actual %0d",
                           want.byte_index, m_tdata[11:8]);
                    error_count++;
                end
                if (m_tlast !== want.field_last) begin
                    $error("field_last mismatch: expected %0d, actual %0d",
                           want.field_last, m_tlast);
                    error_count++;
                end
            end
        end
    end

    initial begin
        int guard;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        idle_on = 1'b1;
        test_idle_drop();
        test_every_tag();
        test_mid_byte_tag();
        test_chained_fields();
        test_random_frames(RANDOM_ITEMS);
        s_tvalid <= 1'b0;
        guard = 0;
        while (pending_bytes.size() != 0 && guard < 20000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (8) @(posedge aclk);
        if (pending_bytes.size() != 0) begin
            $error("%0d expected bytes never arrived", pending_bytes.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("tagged_bit_field_deframer_top test passed");
        end else begin
            $display("tagged_bit_field_deframer_top test failed");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("tagged_bit_field_deframer_top test failed");
        $finish;
    end

endmodule

@@ filelist.f @@
src/tbfd_pkg.sv
src/tbfd_front.sv
src/tbfd_queue.sv
src/tbfd_back.sv
src/tagged_bit_field_deframer_top.sv
sim/testbench.sv
